// File: src/mu8_pkg.sv
// ============================================================================
// mu8_pkg
// Shared types and constants for the modified UTF-8 to UTF-8 converter.
// ============================================================================
`default_nettype none

package mu8_pkg;

   // Position cap of the output index
   localparam int MAX_OUT_LEN = 65535;
   localparam logic [15:0] POS_CAP = 16'((MAX_OUT_LEN < 65535) ? MAX_OUT_LEN : 65535);

   // Held byte store and job queue sizing
   localparam int HELD_DEPTH  = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Byte codes
   localparam logic [7:0] BYTE_ED      = 8'hED;
   localparam logic [7:0] BYTE_C0      = 8'hC0;
   localparam logic [7:0] BYTE_80      = 8'h80;
   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] SURR_LO      = 8'hA0;
   localparam logic [7:0] SURR_HI      = 8'hAF;
   localparam logic [7:0] LEAD4_MARK   = 8'hF0;
   localparam logic [7:0] CONT_MARK    = 8'h80;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_AFTER_C0,
      MODE_AFTER_ED,
      MODE_PAIR
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] out_position;
      logic        run_last;
      logic        string_end;
   } rsp_type;

   // Bytes produced by one input beat
   typedef struct packed {
      logic [HELD_DEPTH-1:0][7:0] data;
      logic [2:0]                 count;
      logic                       last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// File: src/modified_utf8_to_utf8.sv
// ============================================================================
// modified_utf8_to_utf8
// Converts a modified UTF-8 byte stream into standard UTF-8, numbering each
// output byte within its string.
// ============================================================================
//
//   channel  dir  handshake               payload
//   req_     in   req_valid / req_ready   mu8_pkg::req_type  (in_byte, string_last)
//   rsp_     out  rsp_valid / rsp_ready   mu8_pkg::rsp_type  (out_byte, out_position,
//                                                             run_last, string_end)
//
// - Sustains one input beat per cycle while the job queue has room; an input
//   beat yields zero to five output beats, sent one a cycle while rsp_ready holds.
// - An input's output beats pass the job queue, then the output register.
// - A four-entry job queue decouples decoder and serialiser; req_ready drops
//   only while that queue is full.
// - Synchronous reset clears decoder state, queue pointers and output index.
//
// Decoding: C0 80 gives a single NUL; ED A0..AF plus four more bytes gives a
// four-byte sequence; ED or C0 not followed by their partner pass through raw;
// a sequence cut off by string end is flushed raw after the current byte's
// own output.
// ============================================================================
`default_nettype none

module modified_utf8_to_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mu8_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mu8_pkg::rsp_type rsp_payload
);

   mu8_pkg::q_status_type q_status;
   mu8_pkg::job_type      push_job;
   mu8_pkg::job_type      head_job;
   logic                  q_push;
   logic                  q_pop;

   // front: classifies each beat, holds pending sequence bytes, emits a job when the beat yields bytes
   mu8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   // job queue
   mu8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // back: one byte per beat into the output register
   mu8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_job    (head_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: src/mu8_front.sv
// ============================================================================
// mu8_front
// Decoder: takes input beats, tracks pending sequences, builds output jobs.
// ============================================================================
`default_nettype none

module mu8_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mu8_pkg::req_type     req_payload,
   input  mu8_pkg::q_status_type q_status,
   output logic                 q_push,
   output mu8_pkg::job_type     q_job
);

   mu8_pkg::mode_type mode_ff, mode_in;
   logic [2:0]        held_count_ff, held_count_in;
   logic [7:0]        held_ff [mu8_pkg::HELD_DEPTH];

   logic              accept;
   logic [7:0]        b;
   logic              last;
   logic              idle_hold;
   logic              surr_ok;
   logic              pair_done;

   logic [7:0]        pfx [4];
   logic [2:0]        pfx_n;
   logic              hold_en;
   logic [2:0]        wr_idx;
   logic [2:0]        base_n;
   logic [2:0]        nh_n;
   logic [7:0]        nh [mu8_pkg::HELD_DEPTH];
   logic [20:0]       cp;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign b         = req_payload.in_byte;
   assign last      = req_payload.string_last;
   assign idle_hold = (b == mu8_pkg::BYTE_ED) || (b == mu8_pkg::BYTE_C0);
   assign surr_ok   = (b >= mu8_pkg::SURR_LO) && (b <= mu8_pkg::SURR_HI);
   assign pair_done = held_count_ff >= 3'(mu8_pkg::HELD_DEPTH);

   // code point of a completed surrogate pair
   assign cp = mu8_pkg::SUPP_BASE
             + 21'({held_ff[1][3:0], held_ff[2][5:0], held_ff[4][3:0], b[5:0]});

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         unique case (mode_ff)
            mu8_pkg::MODE_AFTER_C0: begin
               if (b == mu8_pkg::BYTE_80) mode_in = mu8_pkg::MODE_IDLE;
               else if (b == mu8_pkg::BYTE_ED) mode_in = mu8_pkg::MODE_AFTER_ED;
               else if (b == mu8_pkg::BYTE_C0) mode_in = mu8_pkg::MODE_AFTER_C0;
               else mode_in = mu8_pkg::MODE_IDLE;
            end
            mu8_pkg::MODE_AFTER_ED: begin
               if (surr_ok) mode_in = mu8_pkg::MODE_PAIR;
               else if (b == mu8_pkg::BYTE_ED) mode_in = mu8_pkg::MODE_AFTER_ED;
               else if (b == mu8_pkg::BYTE_C0) mode_in = mu8_pkg::MODE_AFTER_C0;
               else mode_in = mu8_pkg::MODE_IDLE;
            end
            mu8_pkg::MODE_PAIR: begin
               mode_in = pair_done ? mu8_pkg::MODE_IDLE : mu8_pkg::MODE_PAIR;
            end
            mu8_pkg::MODE_IDLE: begin
               if (b == mu8_pkg::BYTE_ED) mode_in = mu8_pkg::MODE_AFTER_ED;
               else if (b == mu8_pkg::BYTE_C0) mode_in = mu8_pkg::MODE_AFTER_C0;
               else mode_in = mu8_pkg::MODE_IDLE;
            end
            default: mode_in = mu8_pkg::MODE_IDLE;
         endcase
         if (last) mode_in = mu8_pkg::MODE_IDLE;
      end
   end

   // job contents and held store updates
   always_comb begin
      for (int i = 0; i < 4; i++) pfx[i] = mu8_pkg::BYTE_NUL;
      pfx_n   = 3'd0;
      hold_en = 1'b0;
      wr_idx  = 3'd0;
      base_n  = 3'd0;
      unique case (mode_ff)
         mu8_pkg::MODE_AFTER_C0: begin
            if (b == mu8_pkg::BYTE_80) begin
               pfx[0] = mu8_pkg::BYTE_NUL;
               pfx_n  = 3'd1;
            end else begin
               pfx[0] = mu8_pkg::BYTE_C0;
               if (idle_hold) begin
                  pfx_n   = 3'd1;
                  hold_en = 1'b1;
               end else begin
                  pfx[1] = b;
                  pfx_n  = 3'd2;
               end
            end
         end
         mu8_pkg::MODE_AFTER_ED: begin
            if (surr_ok) begin
               hold_en = 1'b1;
               wr_idx  = held_count_ff;
               base_n  = held_count_ff;
            end else begin
               pfx[0] = mu8_pkg::BYTE_ED;
               if (idle_hold) begin
                  pfx_n   = 3'd1;
                  hold_en = 1'b1;
               end else begin
                  pfx[1] = b;
                  pfx_n  = 3'd2;
               end
            end
         end
         mu8_pkg::MODE_PAIR: begin
            if (pair_done) begin
               pfx[0] = mu8_pkg::LEAD4_MARK | {5'd0, cp[20:18]};
               pfx[1] = mu8_pkg::CONT_MARK | {2'd0, cp[17:12]};
               pfx[2] = mu8_pkg::CONT_MARK | {2'd0, cp[11:6]};
               pfx[3] = mu8_pkg::CONT_MARK | {2'd0, cp[5:0]};
               pfx_n  = 3'd4;
            end else begin
               hold_en = 1'b1;
               wr_idx  = held_count_ff;
               base_n  = held_count_ff;
            end
         end
         mu8_pkg::MODE_IDLE: begin
            if (idle_hold) begin
               hold_en = 1'b1;
            end else begin
               pfx[0] = b;
               pfx_n  = 3'd1;
            end
         end
         default: begin
            pfx_n = 3'd0;
         end
      endcase

      nh_n = base_n + {2'd0, hold_en};
      for (int i = 0; i < mu8_pkg::HELD_DEPTH; i++) begin
         nh[i] = (hold_en && (wr_idx == 3'(i))) ? b : held_ff[i];
      end

      // prefix bytes first, then on string end the held bytes flushed raw
      q_job.last  = last;
      q_job.count = pfx_n + (last ? nh_n : 3'd0);
      for (int i = 0; i < mu8_pkg::HELD_DEPTH; i++) begin
         if (3'(i) < pfx_n) q_job.data[i] = pfx[2'(i)];
         else q_job.data[i] = nh[3'(3'(i) - pfx_n)];
      end

      held_count_in = last ? 3'd0 : nh_n;
   end

   assign q_push = accept && (q_job.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mu8_pkg::MODE_IDLE;
         held_count_ff <= 3'd0;
      end else begin
         mode_ff <= mode_in;
         if (accept) held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold_en) held_ff[wr_idx] <= b;
   end

`ifndef ASSERT_OFF
   a_pair_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == mu8_pkg::MODE_PAIR |-> held_count_ff >= 3'd2)
      else $error("pair mode with fewer than two held bytes");
   a_lead_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == mu8_pkg::MODE_AFTER_C0 || mode_ff == mu8_pkg::MODE_AFTER_ED)
      |-> held_count_ff == 3'd1)
      else $error("lead byte pending without exactly one held byte");
`endif

endmodule

`default_nettype wire

// File: src/mu8_queue.sv
// ============================================================================
// mu8_queue
// Short job queue between decoder and serialiser.
// ============================================================================
`default_nettype none

module mu8_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mu8_pkg::job_type      push_job,
   input  logic                  pop,
   output mu8_pkg::job_type      head_job,
   output mu8_pkg::q_status_type status
);

   localparam logic [mu8_pkg::QPTR_W:0] DEPTH_CNT = (mu8_pkg::QPTR_W + 1)'(mu8_pkg::QUEUE_DEPTH);

   mu8_pkg::job_type              entries_ff [mu8_pkg::QUEUE_DEPTH];
   logic [mu8_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mu8_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mu8_pkg::QPTR_W:0]      count_ff, count_in;

   assign status.full  = (count_ff == DEPTH_CNT);
   assign status.empty = (count_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{mu8_pkg::QPTR_W{1'b0}}, push}
                           - {{mu8_pkg::QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

// File: src/mu8_back.sv
// ============================================================================
// mu8_back
// Serialiser: sends the bytes of each job one beat at a time, numbers them.
// ============================================================================
`default_nettype none

module mu8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mu8_pkg::q_status_type q_status,
   input  mu8_pkg::job_type      head_job,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mu8_pkg::rsp_type      rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   mu8_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic [2:0]       sel_ff, sel_in;
   logic [15:0]      out_index_ff, out_index_in;

   logic             load;
   logic             take_last;

   assign load      = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign take_last = (sel_ff == head_job.count - 3'd1);
   assign q_pop     = load && take_last;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      sel_in         = sel_ff;
      out_index_in   = out_index_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.out_byte     = head_job.data[sel_ff];
         rsp_payload_in.out_position = out_index_ff;
         rsp_payload_in.run_last     = take_last;
         rsp_payload_in.string_end   = take_last && head_job.last;
         sel_in                      = take_last ? 3'd0 : sel_ff + 3'd1;
         if (take_last && head_job.last) out_index_in = '0;
         else if (out_index_ff < mu8_pkg::POS_CAP) out_index_in = out_index_ff + 16'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 3'd0;
         out_index_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         out_index_ff <= out_index_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (load && take_last && head_job.last) |=> out_index_ff == '0)
      else $error("output index not restarted after string end");
`endif

endmodule

`default_nettype wire
